// ===== sv/swin_pkg.sv =====
// Shared types and codes for the sliding-window sender.
`timescale 1ns / 1ps
`default_nettype none
package swin_pkg;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // Timer commands on the result channel.
  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEQ_BITS    = 1'd1;

  localparam logic [4:0] WINDOW_SIZE_RST = 5'd4;
  localparam logic [4:0] SEQ_BITS_RST    = 5'd3;

  localparam int SEQ_W      = 16;
  localparam int WORD_W     = 64;
  localparam int BURST_W    = 5;
  localparam logic [BURST_W-1:0] BURST_LAST = 5'd30;  // 31 packets at most per timeout
  localparam logic [1:0] DUP_LIMIT = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;     // capture the accepted word
    logic exec_item;    // apply the item and load its result
    logic walk_init;    // start walking stored packets at the window base
    logic walk_resend;  // the walk is a single fast retransmit
    logic walk_step;    // emit the current walk packet and advance
    logic sel_next;     // index unit reduces next_seq instead of the walk pointer
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       to_empty;    // window empty (base equals next_seq)
    logic       ack_resend;  // the held ack triggers a fast retransmit
    logic       walk_last;   // the current walk packet is the final one
    logic       out_free;    // the result register can take a word this cycle
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/swin_mod_idx.sv =====
// Two-stage reduction of a sequence number to a packet store index.
`timescale 1ns / 1ps
`default_nettype none
module swin_mod_idx #(
  parameter int DEPTH = 32
) (
  input  wire logic                                clk,
  input  wire logic [swin_pkg::SEQ_W-1:0]          seq_in,
  output logic      [$clog2(DEPTH)-1:0]            idx
);
  import swin_pkg::*;

  localparam int IDX_W       = $clog2(DEPTH);
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + DEPTH - 1) / DEPTH;
  localparam int PROD_W      = SEQ_W + RECIP_SHIFT;

  logic [SEQ_W-1:0]  x_r;
  logic [SEQ_W-1:0]  q_r;
  logic [PROD_W-1:0] prod;
  logic [SEQ_W+8:0]  qd;
  logic [SEQ_W-1:0]  rem;

  // Quotient by multiplying with the rounded-up reciprocal; exact for 16-bit inputs.
  assign prod = PROD_W'(seq_in) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    x_r <= seq_in;
    q_r <= prod[PROD_W-1:RECIP_SHIFT];
  end

  assign qd  = (SEQ_W+9)'(q_r) * (SEQ_W+9)'(DEPTH);
  assign rem = x_r - qd[SEQ_W-1:0];
  assign idx = rem[IDX_W-1:0];

endmodule
`default_nettype wire

// ===== sv/swin_dp.sv =====
// Datapath: window state, configuration, packet store and result register.
`timescale 1ns / 1ps
`default_nettype none
module swin_dp #(
  parameter int STORE_DEPTH  = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [swin_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [swin_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic [1:0]                          in_kind,
  input  wire logic [swin_pkg::WORD_W-1:0]         in_payload,
  input  wire logic [swin_pkg::SEQ_W-1:0]          in_ack_num,
  input  wire logic                                in_ack_checksum_ok,
  input  wire swin_pkg::cmd_t                      cmd,
  output swin_pkg::sts_t                           sts,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output logic                                     out_packet_valid,
  output logic      [swin_pkg::SEQ_W-1:0]          out_seq_num,
  output logic      [swin_pkg::WORD_W-1:0]         out_packet_data,
  output logic      [1:0]                          out_timer_cmd,
  output logic                                     out_send_accepted,
  output logic                                     out_last
);
  import swin_pkg::*;

  localparam int IDX_W = $clog2(STORE_DEPTH);

  // Configuration.
  logic [4:0] ws_r;
  logic [4:0] sb_r;

  // Window state.
  logic [SEQ_W-1:0] base_r, base_nxt;
  logic [SEQ_W-1:0] next_r, next_nxt;
  logic [1:0]       dup_r, dup_nxt;

  // Held input word.
  logic [1:0]              kind_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [SEQ_W-1:0]        ack_r;
  logic                    ok_r;

  // Walk over stored packets.
  logic [SEQ_W-1:0]   walk_r;
  logic [BURST_W-1:0] cnt_r;
  logic               resend_r;

  // Packet store.
  logic [PAYLOAD_BITS-1:0] pkt_mem [STORE_DEPTH];
  logic [PAYLOAD_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]        idx;
  logic                    mem_we;

  // Result register.
  logic              ov_r;
  logic              pv_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [WORD_W-1:0] data_r;
  logic [1:0]        tcmd_r;
  logic              acc_r;
  logic              last_r;

  logic [SEQ_W-1:0] mask;
  logic [SEQ_W:0]   lim, nn, b1, tgt, wn;
  logic             full, dup_case, empty_a, resend, walk_last, out_free;
  logic [SEQ_W-1:0] base_a;
  logic [1:0]       dup_a;

  logic              e_pv;
  logic [SEQ_W-1:0]  e_seq;
  logic [WORD_W-1:0] e_data;
  logic [1:0]        e_tcmd;
  logic              e_acc;

  swin_mod_idx #(.DEPTH(STORE_DEPTH)) u_idx (
    .clk    (clk),
    .seq_in (cmd.sel_next ? next_r : walk_r),
    .idx    (idx)
  );

  always_comb begin
    if (sb_r inside {[5'd1:5'd16]}) begin
      mask = SEQ_W'((17'd1 << sb_r) - 17'd1);
    end else begin
      mask = '1;
    end
  end

  assign lim = (17'(base_r) + 17'(ws_r)) & 17'(mask);
  assign nn  = (17'(next_r) + 17'd1) & 17'(mask);
  assign b1  = (17'(base_r) + 17'd1) & 17'(mask);
  assign tgt = (17'(ack_r) + 17'd1) & 17'(mask);
  assign wn  = (17'(walk_r) + 17'd1) & 17'(mask);

  assign full     = (next_r == lim[SEQ_W-1:0]);
  assign dup_case = (base_r == tgt[SEQ_W-1:0]);
  assign base_a   = dup_case ? base_r : tgt[SEQ_W-1:0];
  assign dup_a    = dup_case ? (dup_r + 2'd1) : 2'd0;
  assign empty_a  = (base_a == next_r);
  assign resend   = (kind_r == KIND_ACK) && ok_r && !empty_a && (dup_a == DUP_LIMIT);

  assign walk_last = resend_r || (wn[SEQ_W-1:0] == next_r) || (cnt_r == BURST_LAST);
  assign out_free  = !ov_r || !out_stall;

  assign sts.kind       = kind_r;
  assign sts.to_empty   = (base_r == next_r);
  assign sts.ack_resend = resend;
  assign sts.walk_last  = walk_last;
  assign sts.out_free   = out_free;

  // Result and state change of a send, an ack or an empty-window timeout.
  always_comb begin
    e_pv     = 1'b0;
    e_seq    = '0;
    e_data   = '0;
    e_tcmd   = TMR_NONE;
    e_acc    = 1'b0;
    base_nxt = base_r;
    next_nxt = next_r;
    dup_nxt  = dup_r;
    mem_we   = 1'b0;
    case (kind_r)
      KIND_SEND: begin
        if (!full) begin
          e_pv     = 1'b1;
          e_seq    = next_r;
          e_data   = WORD_W'(pay_r);
          e_tcmd   = (nn == b1) ? TMR_START : TMR_NONE;
          e_acc    = 1'b1;
          next_nxt = nn[SEQ_W-1:0];
          mem_we   = cmd.exec_item;
        end
      end
      KIND_ACK: begin
        if (ok_r) begin
          base_nxt = base_a;
          dup_nxt  = (empty_a || resend) ? 2'd0 : dup_a;
          if (empty_a) begin
            e_tcmd = TMR_STOP;
          end
        end
      end
      KIND_TIMEOUT: begin
        e_tcmd = TMR_RESTART;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= WINDOW_SIZE_RST;
      sb_r   <= SEQ_BITS_RST;
      base_r <= '0;
      next_r <= '0;
      dup_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_WINDOW_SIZE: ws_r <= cfg_wdata;
          CFG_SEQ_BITS:    sb_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd.exec_item) begin
        base_r <= base_nxt;
        next_r <= next_nxt;
        dup_r  <= dup_nxt;
      end
      if ((cmd.exec_item && !resend) || cmd.walk_step) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= in_kind;
      pay_r  <= in_payload[PAYLOAD_BITS-1:0];
      ack_r  <= in_ack_num;
      ok_r   <= in_ack_checksum_ok;
    end
    if (cmd.walk_init) begin
      walk_r   <= base_r;
      cnt_r    <= '0;
      resend_r <= cmd.walk_resend;
    end else if (cmd.walk_step) begin
      walk_r <= wn[SEQ_W-1:0];
      cnt_r  <= cnt_r + 1'b1;
    end
    if (cmd.exec_item && !resend) begin
      pv_r   <= e_pv;
      seq_r  <= e_seq;
      data_r <= e_data;
      tcmd_r <= e_tcmd;
      acc_r  <= e_acc;
      last_r <= 1'b1;
    end else if (cmd.walk_step) begin
      pv_r   <= 1'b1;
      seq_r  <= walk_r;
      data_r <= WORD_W'(rd_data_r);
      tcmd_r <= (walk_last && !resend_r) ? TMR_RESTART : TMR_NONE;
      acc_r  <= 1'b0;
      last_r <= walk_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pkt_mem[idx] <= pay_r;
    end
    rd_data_r <= pkt_mem[idx];
  end

  assign out_valid         = ov_r;
  assign out_packet_valid  = pv_r;
  assign out_seq_num       = seq_r;
  assign out_packet_data   = data_r;
  assign out_timer_cmd     = tcmd_r;
  assign out_send_accepted = acc_r;
  assign out_last          = last_r;

endmodule
`default_nettype wire

// ===== sv/swin_ctrl.sv =====
// Controller state machine sequencing items and store walks.
`timescale 1ns / 1ps
`default_nettype none
module swin_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output swin_pkg::cmd_t       cmd,
  input  wire swin_pkg::sts_t  sts
);
  import swin_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_RD_A = 3'd2;
  localparam logic [2:0] ST_RD_B = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.sel_next    = (state_r == ST_IDLE) || (state_r == ST_EXEC);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.kind == KIND_TIMEOUT && !sts.to_empty) begin
          cmd.walk_init = 1'b1;
          state_nxt     = ST_RD_A;
        end else if (sts.out_free) begin
          cmd.exec_item = 1'b1;
          if (sts.ack_resend) begin
            cmd.walk_init   = 1'b1;
            cmd.walk_resend = 1'b1;
            state_nxt       = ST_RD_A;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RD_A: state_nxt = ST_RD_B;
      ST_RD_B: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.walk_step = 1'b1;
          state_nxt     = sts.walk_last ? ST_IDLE : ST_RD_A;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sliding_window_sender_top.sv =====
// Top level of the go-back-N sliding-window sender with fast retransmit.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one word at a time on the input channel: a send request, an
// arrived acknowledgement or a timer expiry. A send, an ack without fast
// retransmit, a refused send, a bad-checksum ack, an unused kind or a timeout
// with an empty window is accepted into the input register, then applied with
// its result loaded. A fast-retransmit ack updates the window and resends the
// packet at the base; a timeout resends the outstanding packets from the base,
// at most 31 of them. Resent packets pass a registered two-stage unit reducing
// the sequence number to a store index, then the store's one registered read
// port. Each result waits in an output register, so a stall on the result side
// only holds the block once the next result is ready. The packet store is not
// cleared at reset; a sequence number must only be read back after it has been
// sent, and configuration written through the plain write port only while the
// block is idle. Both bind the user; the block itself enforces neither.
module sliding_window_sender_top #(
  parameter int STORE_DEPTH  = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [swin_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [swin_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          in_kind,
  input  wire logic [swin_pkg::WORD_W-1:0]         in_payload,
  input  wire logic [swin_pkg::SEQ_W-1:0]          in_ack_num,
  input  wire logic                                in_ack_checksum_ok,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_packet_valid,
  output logic      [swin_pkg::SEQ_W-1:0]          out_seq_num,
  output logic      [swin_pkg::WORD_W-1:0]         out_packet_data,
  output logic      [1:0]                          out_timer_cmd,
  output logic                                     out_send_accepted,
  output logic                                     out_last
);
  import swin_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller decides when each step runs; it sees the datapath only
  // through the status bundle.
  swin_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath holds the window pointers, the duplicate-ack count, the
  // configuration registers, the packet store and the result register.
  swin_dp #(
    .STORE_DEPTH  (STORE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_kind            (in_kind),
    .in_payload         (in_payload),
    .in_ack_num         (in_ack_num),
    .in_ack_checksum_ok (in_ack_checksum_ok),
    .cmd                (cmd),
    .sts                (sts),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_packet_valid   (out_packet_valid),
    .out_seq_num        (out_seq_num),
    .out_packet_data    (out_packet_data),
    .out_timer_cmd      (out_timer_cmd),
    .out_send_accepted  (out_send_accepted),
    .out_last           (out_last)
  );

endmodule
`default_nettype wire

// ===== tb/tb_sliding_window_sender_top.sv =====
// Self-checking testbench for the sliding-window sender with a predictor and random traffic.
`timescale 1ns / 1ps

import swin_pkg::*;

// One word on the input channel, one field per port.
typedef struct packed {
  logic [1:0]  kind;
  logic [63:0] payload;
  logic [15:0] ack_num;
  logic        ack_ok;
} link_word_t;

// One word on the result channel.
typedef struct packed {
  logic        pkt_valid;
  logic [15:0] seq;
  logic [63:0] data;
  logic [1:0]  tmr;
  logic        accepted;
  logic        last;
} link_result_t;

// Tracks the sender window and the packets it should emit.
class window_book;
  localparam int SLOTS = 32;
  localparam int BURST_MAX = 31;

  int unsigned  win_size;
  int unsigned  seq_width;
  int unsigned  base;
  int unsigned  nxt;
  int unsigned  dups;
  logic [63:0]  store [SLOTS];
  bit           filled [SLOTS];
  link_result_t due [$];
  int           mismatches;
  int           checked;

  function new();
    win_size = WINDOW_SIZE_RST;
    seq_width = SEQ_BITS_RST;
    base = 0;
    nxt = 0;
    dups = 0;
    mismatches = 0;
    checked = 0;
    foreach (filled[k]) begin
      filled[k] = 1'b0;
      store[k] = '0;
    end
  endfunction

  function int unsigned space();
    if (seq_width >= 1 && seq_width <= 16) return 32'd1 << seq_width;
    return 32'd1 << 16;
  endfunction

  function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
    if (addr == CFG_WINDOW_SIZE) win_size = value;
    else if (addr == CFG_SEQ_BITS) seq_width = value;
  endfunction

  function link_result_t make_result(logic v, logic [15:0] s, logic [63:0] d,
                                     logic [1:0] t, logic a, logic l);
    link_result_t r;
    r.pkt_valid = v;
    r.seq = s;
    r.data = d;
    r.tmr = t;
    r.accepted = a;
    r.last = l;
    return r;
  endfunction

  // Works out the results of one word. With commit low the window state is
  // left untouched; blank tells whether a never-written slot would be read.
  function void apply(link_word_t w, bit commit, output bit blank);
    int unsigned  m, tgt, i, n, sb, sn, sd;
    logic [1:0]   tmr;
    bit           done;
    link_result_t fresh [$];
    blank = 1'b0;
    sb = base;
    sn = nxt;
    sd = dups;
    m = space();
    tmr = TMR_NONE;
    case (w.kind)
      KIND_SEND: begin
        if (nxt == (base + win_size) % m) begin
          fresh.push_back(make_result(0, '0, '0, TMR_NONE, 0, 1));
        end else begin
          i = nxt;
          if (commit) begin
            store[i % SLOTS] = w.payload;
            filled[i % SLOTS] = 1'b1;
          end
          nxt = (nxt + 1) % m;
          if (nxt == (base + 1) % m) tmr = TMR_START;
          fresh.push_back(make_result(1, 16'(i), w.payload, tmr, 1, 1));
        end
      end
      KIND_ACK: begin
        if (!w.ack_ok) begin
          fresh.push_back(make_result(0, '0, '0, TMR_NONE, 0, 1));
        end else begin
          tgt = (32'(w.ack_num) + 1) % m;
          if (base == tgt) begin
            dups = (dups + 1) & 3;
          end else begin
            base = tgt;
            dups = 0;
          end
          if (base == nxt) begin
            tmr = TMR_STOP;
            dups = 0;
          end
          if (dups == DUP_LIMIT) begin
            if (!filled[base % SLOTS]) blank = 1'b1;
            fresh.push_back(make_result(1, 16'(base), store[base % SLOTS], tmr, 0, 1));
            dups = 0;
          end else begin
            fresh.push_back(make_result(0, '0, '0, tmr, 0, 1));
          end
        end
      end
      KIND_TIMEOUT: begin
        i = base;
        n = 0;
        if (i == nxt) fresh.push_back(make_result(0, '0, '0, TMR_RESTART, 0, 1));
        while (i != nxt && n < BURST_MAX) begin
          if (!filled[i % SLOTS]) blank = 1'b1;
          n++;
          done = ((i + 1) % m == nxt) || (n == BURST_MAX);
          fresh.push_back(make_result(1, 16'(i), store[i % SLOTS],
                                      done ? TMR_RESTART : TMR_NONE, 0, done));
          i = (i + 1) % m;
        end
      end
      default: begin
        fresh.push_back(make_result(0, '0, '0, TMR_NONE, 0, 1));
      end
    endcase
    if (commit) begin
      foreach (fresh[k]) due.push_back(fresh[k]);
    end else begin
      base = sb;
      nxt = sn;
      dups = sd;
    end
  endfunction

  function void check_result(link_result_t got);
    link_result_t want;
    checked++;
    if (due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result word with nothing expected: valid=%0b seq=%0d data=%h tmr=%0d",
                 got.pkt_valid, got.seq, got.data, got.tmr);
      return;
    end
    want = due.pop_front();
    if (got.pkt_valid !== want.pkt_valid || got.seq !== want.seq ||
        got.data !== want.data || got.tmr !== want.tmr ||
        got.accepted !== want.accepted || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: result %0d expected valid=%0b seq=%0d data=%h tmr=%0d acc=%0b last=%0b",
                 checked, want.pkt_valid, want.seq, want.data, want.tmr,
                 want.accepted, want.last);
        $display("       got          valid=%0b seq=%0d data=%h tmr=%0d acc=%0b last=%0b",
                 got.pkt_valid, got.seq, got.data, got.tmr, got.accepted, got.last);
      end
    end
  endfunction
endclass

module tb_sliding_window_sender_top;

  // Cycles without any handshake on either channel before the run is abandoned.
  // The slowest legal gap is a sender pause, a 31-packet timeout walk and a
  // receiver stall, so this leaves a wide margin.
  localparam int IDLE_LIMIT = 2000;
  // The package names only three kinds; the fourth code is accepted and ignored.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_kind = '0;
  logic [WORD_W-1:0]     in_payload = '0;
  logic [SEQ_W-1:0]      in_ack_num = '0;
  logic                  in_ack_checksum_ok = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_packet_valid;
  logic [SEQ_W-1:0]      out_seq_num;
  logic [WORD_W-1:0]     out_packet_data;
  logic [1:0]            out_timer_cmd;
  logic                  out_send_accepted;
  logic                  out_last;

  window_book book = new();

  // When calm is set neither side inserts idle cycles, so words go back to back.
  bit calm = 1'b0;
  int words_sent = 0;
  int settings_used = 1;
  int idle_run = 0;

  sliding_window_sender_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_payload         (in_payload),
    .in_ack_num         (in_ack_num),
    .in_ack_checksum_ok (in_ack_checksum_ok),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_packet_valid   (out_packet_valid),
    .out_seq_num        (out_seq_num),
    .out_packet_data    (out_packet_data),
    .out_timer_cmd      (out_timer_cmd),
    .out_send_accepted  (out_send_accepted),
    .out_last           (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic link_word_t mk(logic [1:0] kind, logic [63:0] payload,
                                    logic [15:0] ack_num, logic ack_ok);
    link_word_t w;
    w.kind = kind;
    w.payload = payload;
    w.ack_num = ack_num;
    w.ack_ok = ack_ok;
    return w;
  endfunction

  // Offers one word, optionally after a random pause, and holds it until the
  // block takes it. The predictor is updated at the accepting edge, so the
  // next word is always chosen from the state the block will really be in.
  task automatic send_word(link_word_t w);
    int gap;
    bit unused_blank;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= w.kind;
    in_payload <= w.payload;
    in_ack_num <= w.ack_num;
    in_ack_checksum_ok <= w.ack_ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.apply(w, 1'b1, unused_blank);
    words_sent++;
  endtask

  // Stops offering words until every predicted result has come out. It always
  // waits for a clock edge first, so in_valid is never lowered and raised in the
  // same time step.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.due.size() > 0) @(posedge clk);
  endtask

  // Register writes happen only with the block idle. Every word yields at least
  // one result, so once the last result is out the block has nothing left to
  // do; spare cycles after that cover the output register settling.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_reg(addr, value);
  endtask

  // Mostly well-formed traffic: sends, cumulative acks that land inside the
  // outstanding range (often exact duplicates to reach fast retransmit), and
  // timeouts. The rest is noise: random ack numbers, bad checksums and the
  // unused kind.
  function automatic link_word_t pick_word();
    int unsigned m, span, roll, hi, k;
    link_word_t  w;
    m = book.space();
    w.kind = KIND_SEND;
    w.payload = {$urandom, $urandom};
    w.ack_num = 16'($urandom);
    w.ack_ok = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: w.payload = '0;
      1: w.payload = '1;
      default: ;
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      w.kind = KIND_SEND;
    end else if (roll < 83) begin
      w.kind = KIND_ACK;
      w.ack_ok = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 7) != 0) begin
        span = (book.nxt % m + m - book.base % m) % m;
        k = (roll < 65) ? 0 : $urandom_range(0, span);
        hi = 65536 / m - 1;
        // Upper bits above the sequence space are free and get random values.
        w.ack_num = 16'((book.base % m + m - 1 + k) % m + m * $urandom_range(0, hi));
      end
    end else if (roll < 96) begin
      w.kind = KIND_TIMEOUT;
    end else begin
      w.kind = KIND_UNUSED;
    end
    return w;
  endfunction

  // One configuration setting followed by random traffic. Only words that
  // change or read the window count toward the phase length.
  task automatic random_phase(logic [CFG_DATA_W-1:0] ws, logic [CFG_DATA_W-1:0] sb,
                              bit quiet, int quota);
    link_word_t w;
    bit         blank;
    int         done;
    write_reg(CFG_WINDOW_SIZE, ws);
    write_reg(CFG_SEQ_BITS, sb);
    settings_used++;
    calm = quiet;
    done = 0;
    while (done < quota) begin
      w = pick_word();
      // A store slot that was never filled must not be read back; such a
      // timeout or retransmitting ack is swapped for a send.
      book.apply(w, 1'b0, blank);
      if (blank) w.kind = KIND_SEND;
      if (w.kind == KIND_SEND || w.kind == KIND_TIMEOUT || (w.kind == KIND_ACK && w.ack_ok))
        done++;
      send_word(w);
      if ($urandom_range(0, 24) == 0) drain();
    end
  endtask

  // Result side: a random stall before each result, then the word is checked
  // at the edge where it is taken.
  initial begin : result_side
    int           gap;
    link_result_t got;
    forever begin
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(rst_n && out_valid === 1'b1)) @(posedge clk);
      got.pkt_valid = out_packet_valid;
      got.seq = out_seq_num;
      got.data = out_packet_data;
      got.tmr = out_timer_cmd;
      got.accepted = out_send_accepted;
      got.last = out_last;
      book.check_result(got);
    end
  end

  // Watchdog: any handshake on either channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles, %0d results still expected",
               IDLE_LIMIT, book.due.size());
      $display("tb_sliding_window_sender_top NOT OK");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset setting: a window of four in a space of eight.
    // A timeout and an ack on an empty window: restart alone, then a stop.
    send_word(mk(KIND_TIMEOUT, '1, 16'hFFFF, 1'b1));
    send_word(mk(KIND_ACK, '0, 16'd7, 1'b1));
    // Fill the window with extreme payloads; the first send starts the timer.
    send_word(mk(KIND_SEND, '0, '0, 1'b0));
    send_word(mk(KIND_SEND, '1, '0, 1'b0));
    send_word(mk(KIND_SEND, 64'h5555_5555_5555_5555, 16'hFFFF, 1'b1));
    send_word(mk(KIND_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 16'hFFFF, 1'b1));
    // The window is full, so this send is refused.
    send_word(mk(KIND_SEND, 64'h0123_4567_89AB_CDEF, '0, 1'b0));
    // Timeout resends all four outstanding packets.
    send_word(mk(KIND_TIMEOUT, '0, '0, 1'b0));
    // A bad checksum changes nothing.
    send_word(mk(KIND_ACK, '1, 16'hFFFF, 1'b0));
    // Three duplicate acks of the packet before the base trigger a fast retransmit.
    send_word(mk(KIND_ACK, '0, 16'd7, 1'b1));
    send_word(mk(KIND_ACK, '0, 16'd7, 1'b1));
    send_word(mk(KIND_ACK, '0, 16'd7, 1'b1));
    // A new base, then the unused kind, then an ack that empties the window.
    send_word(mk(KIND_ACK, '0, 16'd1, 1'b1));
    send_word(mk(KIND_UNUSED, '1, 16'hFFFF, 1'b1));
    send_word(mk(KIND_ACK, '0, 16'd3, 1'b1));
    // Send into the empty window, then an ack number that wraps the space and
    // pulls the base back, and a timeout over the wider span that results.
    send_word(mk(KIND_SEND, 64'hDEAD_BEEF_F00D_CAFE, '0, 1'b0));
    send_word(mk(KIND_ACK, '0, 16'hFFFF, 1'b1));
    send_word(mk(KIND_TIMEOUT, '0, '0, 1'b0));
    // Hold off until everything above has come out.
    drain();

    // Random phases over the register extremes and the odd settings: a full
    // 16-bit space, a shrink to 3 bits with state left beyond it, a single-slot
    // window in a space of two, a window of 31, a window of zero, and sequence
    // widths of zero and above 16 that fall back to 16 bits.
    random_phase(5'd31, 5'd16, 1'b0, 12);
    random_phase(5'd4,  5'd3,  1'b1, 12);
    random_phase(5'd1,  5'd1,  1'b0, 12);
    random_phase(5'd31, 5'd5,  1'b0, 12);
    random_phase(5'd0,  5'd4,  1'b0, 12);
    random_phase(5'd7,  5'd0,  1'b1, 12);
    random_phase(5'd16, 5'd20, 1'b0, 12);

    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (book.due.size() > 0) begin
      book.mismatches += book.due.size();
      $display("ERROR: %0d expected results never arrived", book.due.size());
    end
    $display("Summary: %0d input words under %0d register settings, %0d results checked.",
             words_sent, settings_used, book.checked);
    $display("Summary: %0d mismatching or missing results.", book.mismatches);
    if (book.mismatches == 0) begin
      $display("tb_sliding_window_sender_top OK");
    end else begin
      $display("tb_sliding_window_sender_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/swin_pkg.sv
sv/swin_mod_idx.sv
sv/swin_dp.sv
sv/swin_ctrl.sv
sv/sliding_window_sender_top.sv
tb/tb_sliding_window_sender_top.sv
